@@ sv/tcce_pkg.sv @@
// Package with the shared types and constants of the text console cursor engine.
`default_nettype none
package tcce_pkg;

  localparam int CELL_W = 16;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] COLOR_RESET  = 8'h0A;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_BLANK,
    ST_DONE
  } st_t;

endpackage
`default_nettype wire

@@ sv/text_console_cursor_engine.sv @@
// Top level of the text console: cursor control, row rotation and the cell memory.
//
//  channel | handshake              | payload
//  in      | in_tvalid / in_tready  | in_tuser mode, in_tdata char, row, col
//  out     | out_tvalid / out_tready| out_tdata cell, cursor, scrolled
//  cfg     | cfg_valid / cfg_ready  | cfg_data text color
//
// A put without scroll or a no-op passes from IDLE to DONE and back to IDLE,
// and a read also passes through READ for the registered memory read.
// A put that scrolls first blanks one memory row in BLANK, through the single write port;
// the grid itself is rotated by a row offset.
// A clear passes through FILL, one cell written per cycle, before DONE.
// After reset a clearing pass over SCREEN_HEIGHT * SCREEN_WIDTH cells runs with in_tready low.
// A result waits in the output register while the next item is taken.
`default_nettype none
module text_console_cursor_engine #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: char_code[7:0], read_row[12:8], read_col[19:13].
  input  wire logic [23:0] in_tdata,
  // Fields from bit 0: mode[1:0].
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: cell_char[7:0], cell_color[15:8], cursor_row[20:16],
  // cursor_col[27:21], scrolled[28].
  output logic      [31:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import tcce_pkg::*;

  localparam int RW    = $clog2(SCREEN_HEIGHT);
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int AW    = RW + CW;
  localparam int DEPTH = SCREEN_HEIGHT * (1 << CW);
  localparam int TW    = $clog2(SCREEN_WIDTH + TAB_STOP);
  localparam int NSTOP = (SCREEN_WIDTH - 1) / TAB_STOP + 1;

  st_t state_r, state_nxt;

  logic [7:0]    text_color_r;
  logic [7:0]    fill_color_r;
  logic          fill_reply_r;
  logic [RW-1:0] cur_row_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] top_r;
  logic [RW-1:0] fill_row_r;
  logic [CW-1:0] fill_col_r;
  logic [RW-1:0] blank_row_r;
  logic          res_range_r;
  logic          res_read_r;
  logic          res_scroll_r;
  logic [7:0]    res_char_r;
  logic [7:0]    res_color_r;
  logic          out_valid_r;
  logic [28:0]   out_data_r;

  logic [1:0]    in_mode;
  logic [7:0]    in_char;
  logic [4:0]    in_row;
  logic [6:0]    in_col;
  logic          in_acc;
  logic          out_free;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic [RW:0]   cur_sum;
  logic [RW-1:0] cur_prow;
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_prow;
  logic          rd_in_range;
  logic [RW-1:0] top_inc;
  logic [RW:0]   row_p1;
  logic [CW:0]   col_p1;
  logic [TW-1:0] tab_col;
  logic          adv_row;
  logic [RW-1:0] new_row;
  logic [CW-1:0] new_col;
  logic          new_scroll;
  logic          fill_col_last;
  logic          fill_row_last;

  assign in_mode  = in_tuser;
  assign in_char  = in_tdata[7:0];
  assign in_row   = in_tdata[12:8];
  assign in_col   = in_tdata[19:13];
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign fill_col_last = (fill_col_r == CW'(SCREEN_WIDTH - 1));
  assign fill_row_last = (fill_row_r == RW'(SCREEN_HEIGHT - 1));

  // Logical rows map to memory rows through the rotating top-row offset.
  always_comb begin
    cur_sum  = {1'b0, cur_row_r} + {1'b0, top_r};
    cur_prow = (cur_sum >= (RW + 1)'(SCREEN_HEIGHT)) ?
               RW'(cur_sum - (RW + 1)'(SCREEN_HEIGHT)) : RW'(cur_sum);
    rd_sum   = (RW + 1)'(in_row) + {1'b0, top_r};
    rd_prow  = (rd_sum >= (RW + 1)'(SCREEN_HEIGHT)) ?
               RW'(rd_sum - (RW + 1)'(SCREEN_HEIGHT)) : RW'(rd_sum);
    rd_in_range = (32'(in_row) < SCREEN_HEIGHT) && (32'(in_col) < SCREEN_WIDTH);
    top_inc  = (top_r == RW'(SCREEN_HEIGHT - 1)) ? '0 : top_r + RW'(1);
  end

  always_comb begin
    tab_col = TW'(NSTOP * TAB_STOP);
    for (int k = NSTOP; k >= 1; k--) begin
      if (TW'(k * TAB_STOP) > TW'(cur_col_r)) begin
        tab_col = TW'(k * TAB_STOP);
      end
    end
  end

  always_comb begin
    row_p1     = {1'b0, cur_row_r} + (RW + 1)'(1);
    col_p1     = {1'b0, cur_col_r} + (CW + 1)'(1);
    adv_row    = 1'b0;
    new_row    = cur_row_r;
    new_col    = cur_col_r;
    new_scroll = 1'b0;
    case (in_char)
      CH_NEWLINE: begin
        adv_row = 1'b1;
      end
      CH_BACKSPACE: begin
        if (cur_col_r != '0) begin
          new_col = cur_col_r - CW'(1);
        end
      end
      CH_TAB: begin
        if (tab_col >= TW'(SCREEN_WIDTH)) begin
          adv_row = 1'b1;
        end else begin
          new_col = CW'(tab_col);
        end
      end
      default: begin
        if (col_p1 >= (CW + 1)'(SCREEN_WIDTH)) begin
          adv_row = 1'b1;
        end else begin
          new_col = CW'(col_p1);
        end
      end
    endcase
    if (adv_row) begin
      new_col = '0;
      if (row_p1 >= (RW + 1)'(SCREEN_HEIGHT)) begin
        new_scroll = 1'b1;
        new_row    = RW'(SCREEN_HEIGHT - 1);
      end else begin
        new_row = RW'(row_p1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (fill_col_last && fill_row_last) begin
          state_nxt = fill_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_PUT:   state_nxt = new_scroll ? ST_BLANK : ST_DONE;
            MODE_READ:  state_nxt = ST_READ;
            MODE_CLEAR: state_nxt = ST_FILL;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_BLANK: begin
        if (fill_col_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {cur_prow, cur_col_r};
    mem_wdata = {text_color_r, in_char};
    mem_raddr = {rd_prow, CW'(in_col)};
    case (state_r)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {fill_row_r, fill_col_r};
        mem_wdata = {fill_color_r, CH_SPACE};
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_we    = in_tvalid && (in_mode == MODE_PUT);
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {blank_row_r, fill_col_r};
        mem_wdata = {text_color_r, CH_SPACE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      text_color_r <= COLOR_RESET;
      fill_color_r <= COLOR_RESET;
      fill_reply_r <= 1'b0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      top_r        <= '0;
      fill_row_r   <= '0;
      fill_col_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        text_color_r <= cfg_data;
      end
      if (state_r == ST_FILL || state_r == ST_BLANK) begin
        fill_col_r <= fill_col_last ? '0 : fill_col_r + CW'(1);
      end
      if (state_r == ST_FILL && fill_col_last) begin
        fill_row_r <= fill_row_last ? '0 : fill_row_r + RW'(1);
      end
      if (state_r == ST_IDLE && in_acc) begin
        case (in_mode)
          MODE_PUT: begin
            cur_row_r <= new_row;
            cur_col_r <= new_col;
            if (new_scroll) begin
              top_r <= top_inc;
            end
          end
          MODE_CLEAR: begin
            cur_row_r    <= '0;
            cur_col_r    <= '0;
            top_r        <= '0;
            fill_color_r <= text_color_r;
            fill_reply_r <= 1'b1;
          end
          default: begin
            fill_reply_r <= fill_reply_r;
          end
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      res_range_r  <= rd_in_range;
      res_read_r   <= (in_mode == MODE_READ);
      res_scroll_r <= (in_mode == MODE_PUT) && new_scroll;
      blank_row_r  <= top_r;
    end
    if (state_r == ST_READ) begin
      res_char_r  <= res_range_r ? mem_rdata[7:0] : 8'h00;
      res_color_r <= res_range_r ? mem_rdata[15:8] : 8'h00;
    end else if (state_r == ST_IDLE) begin
      res_char_r  <= 8'h00;
      res_color_r <= 8'h00;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {res_scroll_r, 7'(cur_col_r), 5'(cur_row_r), res_color_r, res_char_r};
    end
  end

  tcce_cell_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};
  assign cfg_ready  = 1'b1;

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < SCREEN_HEIGHT)
    else $error("cursor row left the grid");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) < SCREEN_WIDTH)
    else $error("cursor column left the grid");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) < SCREEN_HEIGHT)
    else $error("top row offset out of range");

  a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_DONE) |-> !mem_we)
    else $error("cell write while a result is pending");

  a_scroll_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_acc && in_mode == MODE_PUT && new_scroll) |=>
    (state_r == ST_BLANK && fill_col_r == '0))
    else $error("scroll did not start a row blanking pass at column zero");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_read_r) |-> (res_char_r == 8'h00 && res_color_r == 8'h00))
    else $error("cell field set by an item that is not a read");

endmodule
`default_nettype wire

@@ sv/tcce_cell_ram.sv @@
// Cell memory of the console with one write port and one registered read port.
`default_nettype none
module tcce_cell_ram #(
  parameter int AW    = 12,
  parameter int DEPTH = 3200
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [tcce_pkg::CELL_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [tcce_pkg::CELL_W-1:0] rdata
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ tb/text_console_checker.sv @@
// Checker for the text console: tracks the grid and cursor, predicts each result and compares.
module text_console_checker
  import tcce_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int TAB_STOP      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          scroll_count
);

  typedef struct packed {
    logic       scrolled;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_color;
    logic [7:0] cell_char;
  } console_result_t;

  logic [7:0] grid_char  [SCREEN_HEIGHT][SCREEN_WIDTH];
  logic [7:0] grid_color [SCREEN_HEIGHT][SCREEN_WIDTH];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0] text_color;
  console_result_t expected_q[$];
  int n_accepted = 0;
  int n_returned = 0;
  int mismatches = 0;
  int scrolls = 0;

  assign pending      = n_accepted - n_returned;
  assign fail_count   = mismatches;
  assign scroll_count = scrolls;

  function automatic void blank_grid(input logic [7:0] color);
    for (int r = 0; r < SCREEN_HEIGHT; r++) begin
      for (int c = 0; c < SCREEN_WIDTH; c++) begin
        grid_char[r][c]  = CH_SPACE;
        grid_color[r][c] = color;
      end
    end
  endfunction

  function automatic void scroll_grid();
    for (int r = 0; r < SCREEN_HEIGHT - 1; r++) begin
      for (int c = 0; c < SCREEN_WIDTH; c++) begin
        grid_char[r][c]  = grid_char[r + 1][c];
        grid_color[r][c] = grid_color[r + 1][c];
      end
    end
    for (int c = 0; c < SCREEN_WIDTH; c++) begin
      grid_char[SCREEN_HEIGHT - 1][c]  = CH_SPACE;
      grid_color[SCREEN_HEIGHT - 1][c] = text_color;
    end
  endfunction

  function automatic logic put_char(input logic [7:0] ch);
    if (cur_row < SCREEN_HEIGHT && cur_col < SCREEN_WIDTH) begin
      grid_char[cur_row][cur_col]  = ch;
      grid_color[cur_row][cur_col] = text_color;
    end
    case (ch)
      CH_NEWLINE: begin
        cur_col = 0;
        cur_row++;
      end
      CH_BACKSPACE: begin
        if (cur_col != 0) cur_col--;
      end
      CH_TAB: begin
        cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
        if (cur_col >= SCREEN_WIDTH) begin
          cur_col = 0;
          cur_row++;
        end
      end
      default: begin
        cur_col++;
        if (cur_col >= SCREEN_WIDTH) begin
          cur_col = 0;
          cur_row++;
        end
      end
    endcase
    if (cur_row >= SCREEN_HEIGHT) begin
      scroll_grid();
      cur_row = SCREEN_HEIGHT - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t predict_result(input logic [1:0] mode,
                                                     input logic [7:0] ch,
                                                     input logic [4:0] rr,
                                                     input logic [6:0] rc);
    console_result_t res;
    res = '0;
    case (mode)
      MODE_PUT: res.scrolled = put_char(ch);
      MODE_READ: begin
        if (rr < SCREEN_HEIGHT && rc < SCREEN_WIDTH) begin
          res.cell_char  = grid_char[rr][rc];
          res.cell_color = grid_color[rr][rc];
        end
      end
      MODE_CLEAR: begin
        blank_grid(text_color);
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    res.cursor_row = 5'(cur_row);
    res.cursor_col = 7'(cur_col);
    return res;
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    console_result_t got;
    if (!rst_n) begin
      text_color = COLOR_RESET;
      cur_row = 0;
      cur_col = 0;
      blank_grid(COLOR_RESET);
      expected_q.delete();
      n_accepted <= 0;
      n_returned <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[28:0];
        n_returned <= n_returned + 1;
        if (expected_q.size() == 0) begin
          $error("Result %h arrived with no item outstanding.", out_tdata);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += field_diff("cell_char", want.cell_char, got.cell_char)
                      + field_diff("cell_color", want.cell_color, got.cell_color)
                      + field_diff("cursor_row", want.cursor_row, got.cursor_row)
                      + field_diff("cursor_col", want.cursor_col, got.cursor_col)
                      + field_diff("scrolled", want.scrolled, got.scrolled);
        end
      end
      if (cfg_valid && cfg_ready) text_color = cfg_data;
      if (in_tvalid && in_tready) begin
        want = predict_result(in_tuser, in_tdata[7:0], in_tdata[12:8], in_tdata[19:13]);
        if (want.scrolled) scrolls++;
        expected_q.push_back(want);
        n_accepted <= n_accepted + 1;
      end
    end
  end

endmodule

@@ tb/tb_text_console_cursor_engine.sv @@
// Testbench top for the text console: reset, stimulus, flow control and the verdict.
module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int SCREEN_WIDTH      = 80;
  localparam int SCREEN_HEIGHT     = 25;
  localparam int TAB_STOP          = 8;
  localparam logic [1:0] MODE_NOP  = 2'd3;
  localparam int RANDOM_ITEMS      = 1050;
  localparam int PHASES            = 6;
  localparam int MAX_RANDOM_CLEARS = 12;
  localparam int HOLD_AT           = 400;
  localparam int HOLD_CYCLES       = 300;
  localparam int DRAIN_CYCLES      = 2 * SCREEN_WIDTH + 20;
  localparam int CYCLE_LIMIT       = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // char_code[7:0], read_row[12:8], read_col[19:13]
  logic [1:0]  in_tuser = '0;  // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // cell_char, cell_color, cursor_row, cursor_col, scrolled
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int scroll_count;
  int cycles = 0;
  int n_sent = 0;
  int n_puts = 0;
  int n_reads = 0;
  int n_outside = 0;
  int n_clears = 0;
  int n_nops = 0;
  int n_colors = 0;
  int n_results = 0;
  int clears_left = MAX_RANDOM_CLEARS;

  always #5 clk = ~clk;

  text_console_cursor_engine #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TAB_STOP     (TAB_STOP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  text_console_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TAB_STOP     (TAB_STOP)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .scroll_count(scroll_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc);
    int gap;
    gap = ((n_sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, rc, rr, ch};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    case (mode)
      MODE_PUT:   n_puts++;
      MODE_READ: begin
        n_reads++;
        if (rr >= SCREEN_HEIGHT || rc >= SCREEN_WIDTH) n_outside++;
      end
      MODE_CLEAR: n_clears++;
      default:    n_nops++;
    endcase
  endtask

  task automatic put(input logic [7:0] ch);
    send_item(MODE_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
    send_item(MODE_READ, 8'($urandom), rr, rc);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_colors++;
  endtask

  task automatic text_run();
    int kind;
    int len;
    kind = $urandom_range(0, 2);
    case (kind)
      0: begin
        len = $urandom_range(5, 30);
        repeat (len) put(CH_NEWLINE);
      end
      1: begin
        len = $urandom_range(2, 11);
        repeat (len) put(CH_TAB);
      end
      default: begin
        len = $urandom_range(10, 90);
        repeat (len) put(8'($urandom_range(32, 126)));
      end
    endcase
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) put(8'($urandom_range(32, 126)));
    else if (pick < 50) put(8'($urandom));
    else if (pick < 58) put(CH_NEWLINE);
    else if (pick < 63) put(CH_TAB);
    else if (pick < 68) put(CH_BACKSPACE);
    else if (pick < 82) begin
      read_cell(5'($urandom_range(0, SCREEN_HEIGHT - 1)),
                7'($urandom_range(0, SCREEN_WIDTH - 1)));
    end else if (pick < 88) read_cell(5'($urandom), 7'($urandom));
    else if (pick < 92) send_item(MODE_NOP, 8'($urandom), 5'($urandom), 7'($urandom));
    else if (pick < 93 && clears_left > 0) begin
      clears_left--;
      send_item(MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    end else text_run();
  endtask

  // The receiver stalls before some results, runs without stalls in stretches, and once holds off for a long time.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && n_results >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = ((n_results / 64) % 4 == 3) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_results++;
    end
  end

  initial begin
    int phase_end;
    logic [7:0] color;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    read_cell(5'd0, 7'd0);
    read_cell(5'(SCREEN_HEIGHT - 1), 7'(SCREEN_WIDTH - 1));
    read_cell(5'h1F, 7'h7F);
    read_cell(5'(SCREEN_HEIGHT), 7'd5);
    read_cell(5'd3, 7'(SCREEN_WIDTH));
    put("A");
    read_cell(5'd0, 7'd0);
    put(8'hFF);
    put(8'h00);
    repeat (4) put(CH_BACKSPACE);
    read_cell(5'd0, 7'd1);
    put(CH_TAB);
    send_item(MODE_NOP, 8'hFF, 5'h1F, 7'h7F);
    put(CH_NEWLINE);
    read_cell(5'd0, 7'd0);
    send_item(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
    read_cell(5'd0, 7'd2);
    read_cell(5'd1, 7'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == 0) color = 8'h00;
      else if (p == 1) color = 8'hFF;
      else if (p == 2) color = 8'hF0;
      else if (p == 3) color = 8'h0F;
      else color = 8'($urandom);
      write_color(color);
      phase_end = n_sent + RANDOM_ITEMS / PHASES;
      while (n_sent < phase_end) random_item();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d puts, %0d reads (%0d off the grid), %0d clears, %0d no-ops.",
             n_sent, n_puts, n_reads, n_outside, n_clears, n_nops);
    $display("Checked %0d results with %0d scrolls under %0d color settings.",
             n_results, scroll_count, n_colors);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tcce_pkg.sv
sv/tcce_cell_ram.sv
sv/text_console_cursor_engine.sv
tb/text_console_checker.sv
tb/tb_text_console_cursor_engine.sv
